// ----- rtl/core/snp_pkg.sv -----
// ----------------------------------------------------------------------------
// snp_pkg
// Shared widths, codes, types and helpers of the sorting network partner unit.
// ----------------------------------------------------------------------------
package snp_pkg;

  // largest floor log2 of the network size
  localparam int SIZE_LOG2_MAX = 16;

  // field widths
  localparam int RANK_W   = 16;
  localparam int STAGE_W  = 17;
  localparam int SIZE_W   = 17;
  localparam int ANS_W    = 17;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 3;
  localparam int LG_W     = 5;
  // stage index inside a batcher or bitonic network (below 136)
  localparam int SIDX_W   = 8;
  // level inside a batcher or bitonic network (below 16)
  localparam int LVL_W    = 4;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_KIND = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PARTNER = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COUNT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd2;

  // network kinds
  localparam logic [KIND_W-1:0] KIND_HC_LH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HC_HL   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OET     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ODD     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EVEN    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BATCHER = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BITONIC = 3'd6;

  // work the back part has to do on a classified item
  typedef enum logic [1:0] {
    OP_DIRECT,
    OP_BATCHER,
    OP_BITONIC
  } op_t;

  // configuration as seen by the front part
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] size;
  } cfg_t;

  // classified item travelling from front to back
  typedef struct packed {
    op_t                 op;
    logic [STATUS_W-1:0] status;
    logic [ANS_W-1:0]    answer;
    logic [RANK_W-1:0]   rank;
    logic [SIDX_W-1:0]   stage;
    logic [LG_W-1:0]     lg;
    logic [SIZE_W-1:0]   size;
  } cmd_t;

  // floor log2, zero for zero, capped at SIZE_LOG2_MAX
  function automatic logic [LG_W-1:0] floor_log2(input logic [SIZE_W-1:0] v);
    logic [LG_W-1:0] lg;
    lg = '0;
    for (int b = 0; b < SIZE_W; b++) begin
      if (v[b]) lg = LG_W'(b);
    end
    if (lg > LG_W'(SIZE_LOG2_MAX)) lg = LG_W'(SIZE_LOG2_MAX);
    return lg;
  endfunction

endpackage

// ----- rtl/core/snp_front.sv -----
// ----------------------------------------------------------------------------
// snp_front
// Classifies a query: stage count, range checks, and the partner for the
// networks that need no walk over levels.
// ----------------------------------------------------------------------------
module snp_front (
  input  snp_pkg::cfg_t                       cfg,
  input  logic [snp_pkg::RANK_W-1:0]          rank,
  input  logic signed [snp_pkg::STAGE_W-1:0]  stage,
  output snp_pkg::cmd_t                       cmd
);

  logic [snp_pkg::LG_W-1:0]   lg;
  logic [8:0]                 tri_prod;
  logic [snp_pkg::SIZE_W-1:0] stages;
  logic                       has_stages;
  logic                       rank_ok;
  logic                       stage_neg;
  logic                       stage_ok;
  logic [snp_pkg::SIZE_W-1:0] stage_u;
  logic [snp_pkg::SIZE_W-1:0] rank_x;
  logic [snp_pkg::LVL_W-1:0]  hl_shift;
  logic                       step_up;
  logic [snp_pkg::SIZE_W-1:0] neighbour;
  logic [snp_pkg::ANS_W-1:0]  partner;

  // network depth
  assign lg       = snp_pkg::floor_log2(cfg.size);
  assign tri_prod = 9'(lg) * (9'(lg) + 9'd1);

  always_comb begin
    stages     = '0;
    has_stages = 1'b0;
    case (cfg.kind)
      snp_pkg::KIND_HC_LH, snp_pkg::KIND_HC_HL: begin
        stages     = snp_pkg::SIZE_W'(lg);
        has_stages = (lg != '0);
      end
      snp_pkg::KIND_OET: begin
        stages     = (cfg.size == snp_pkg::SIZE_W'(2)) ? snp_pkg::SIZE_W'(1) : cfg.size;
        has_stages = (cfg.size >= snp_pkg::SIZE_W'(2));
      end
      snp_pkg::KIND_ODD, snp_pkg::KIND_EVEN: begin
        stages     = snp_pkg::SIZE_W'(1);
        has_stages = 1'b1;
      end
      snp_pkg::KIND_BATCHER, snp_pkg::KIND_BITONIC: begin
        stages     = snp_pkg::SIZE_W'(tri_prod[8:1]);
        has_stages = (lg != '0);
      end
      default: begin
        stages     = '0;
        has_stages = 1'b0;
      end
    endcase
  end

  // range checks
  assign rank_x    = {1'b0, rank};
  assign stage_u   = {1'b0, stage[snp_pkg::STAGE_W-2:0]};
  assign stage_neg = stage[snp_pkg::STAGE_W-1];
  assign rank_ok   = rank_x < cfg.size;
  assign stage_ok  = stage_u < stages;

  // neighbour steps, clamped to the network
  assign hl_shift = snp_pkg::LVL_W'(lg - snp_pkg::LG_W'(1) - stage[snp_pkg::LG_W-1:0]);

  always_comb begin
    case (cfg.kind)
      snp_pkg::KIND_OET:  step_up = (stage[0] == rank[0]);
      snp_pkg::KIND_ODD:  step_up = ~rank[0];
      default:            step_up = rank[0];
    endcase
  end

  always_comb begin
    if (step_up) begin
      neighbour = (rank_x + snp_pkg::SIZE_W'(1) == cfg.size) ? rank_x
                                                             : rank_x + snp_pkg::SIZE_W'(1);
    end else begin
      neighbour = (rank == '0) ? '0 : rank_x - snp_pkg::SIZE_W'(1);
    end
  end

  always_comb begin
    case (cfg.kind)
      snp_pkg::KIND_HC_LH:
        partner = {1'b0, rank ^ (snp_pkg::RANK_W'(1) << stage[snp_pkg::LVL_W-1:0])};
      snp_pkg::KIND_HC_HL:
        partner = {1'b0, rank ^ (snp_pkg::RANK_W'(1) << hl_shift)};
      default:
        partner = neighbour;
    endcase
  end

  // classified item
  always_comb begin
    cmd.op     = snp_pkg::OP_DIRECT;
    cmd.status = snp_pkg::ST_DONE;
    cmd.answer = '0;
    cmd.rank   = rank;
    cmd.stage  = stage[snp_pkg::SIDX_W-1:0];
    cmd.lg     = lg;
    cmd.size   = cfg.size;
    if (has_stages && rank_ok) begin
      if (stage_neg) begin
        cmd.status = snp_pkg::ST_COUNT;
        cmd.answer = stages;
      end else if (stage_ok) begin
        cmd.status = snp_pkg::ST_PARTNER;
        case (cfg.kind)
          snp_pkg::KIND_BATCHER: cmd.op = snp_pkg::OP_BATCHER;
          snp_pkg::KIND_BITONIC: cmd.op = snp_pkg::OP_BITONIC;
          default:               cmd.answer = partner;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/snp_queue.sv -----
// ----------------------------------------------------------------------------
// snp_queue
// Short queue of classified items between the front and the back part.
// ----------------------------------------------------------------------------
module snp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  snp_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output snp_pkg::cmd_t rd_data,
  output logic          empty
);

  localparam int PTR_W = (snp_pkg::QUEUE_DEPTH > 1) ? $clog2(snp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(snp_pkg::QUEUE_DEPTH + 1);

  snp_pkg::cmd_t    slots [snp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(snp_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(snp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(snp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) count <= count + CNT_W'(1);
      else if (rd_en && !wr_en) count <= count - CNT_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

endmodule

// ----- rtl/core/snp_back.sv -----
// ----------------------------------------------------------------------------
// snp_back
// Carries out classified items: walks the levels of the batcher and bitonic
// networks one per cycle and holds the finished result for the receiver.
// ----------------------------------------------------------------------------
module snp_back (
  input  logic                            clk,
  input  logic                            rst,
  input  snp_pkg::cmd_t                   q_data,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  logic                            pop,
  output logic                            empty,
  output logic [snp_pkg::STATUS_W-1:0]    status,
  output logic [snp_pkg::ANS_W-1:0]       answer,
  output logic                            up_flag
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_PICK,
    S_EMIT
  } state_t;

  state_t                       state;
  logic                         out_valid;
  logic                         out_free;
  logic                         out_load;
  snp_pkg::op_t                 op;
  logic [snp_pkg::RANK_W-1:0]   rank;
  logic [snp_pkg::LG_W-1:0]     lg;
  logic [snp_pkg::SIZE_W-1:0]   size;
  logic [snp_pkg::SIDX_W-1:0]   rem;
  logic [snp_pkg::LVL_W-1:0]    level;
  logic [snp_pkg::RANK_W-1:0]   p_mask;
  logic [snp_pkg::RANK_W-1:0]   gap;
  logic [snp_pkg::RANK_W-1:0]   r_val;
  logic [snp_pkg::ANS_W-1:0]    bit_partner;
  logic                         bit_up;

  logic [snp_pkg::RANK_W-1:0]   top;
  logic [snp_pkg::RANK_W-1:0]   p_next;
  logic [snp_pkg::RANK_W-1:0]   d_next;
  logic [snp_pkg::RANK_W-1:0]   r_next;
  logic [snp_pkg::LVL_W-1:0]    rem_lo;
  logic [snp_pkg::LG_W-1:0]     up_pos;
  logic [snp_pkg::SIZE_W-1:0]   rank_x;
  logic [snp_pkg::SIZE_W-1:0]   rank_up;
  logic [snp_pkg::RANK_W-1:0]   rank_dn;
  logic [snp_pkg::ANS_W-1:0]    bat_partner;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign q_pop    = (state == S_IDLE) && !q_empty &&
                    ((q_data.op != snp_pkg::OP_DIRECT) || out_free);

  // a new result beat enters the output register
  assign out_load = (q_pop && (q_data.op == snp_pkg::OP_DIRECT)) ||
                    ((state == S_EMIT) && out_free);

  // exchange pattern of the level reached by the walk
  assign rem_lo = rem[snp_pkg::LVL_W-1:0];
  assign top    = snp_pkg::RANK_W'(1) << snp_pkg::LVL_W'(lg - snp_pkg::LG_W'(1));
  assign p_next = top >> level;
  always_comb begin
    if (rem == '0) begin
      d_next = p_next;
      r_next = '0;
    end else begin
      d_next = (top >> (rem_lo - snp_pkg::LVL_W'(1))) - p_next;
      r_next = p_next;
    end
  end
  assign up_pos = snp_pkg::LG_W'(level) + snp_pkg::LG_W'(1);

  // batcher partner from the registered pattern
  assign rank_x  = {1'b0, rank};
  assign rank_up = rank_x + {1'b0, gap};
  assign rank_dn = rank - gap;
  always_comb begin
    if ((rank & p_mask) == r_val) begin
      bat_partner = rank_up;
    end else if ((rank >= gap) && ((rank_dn & p_mask) == r_val)) begin
      bat_partner = {1'b0, rank_dn};
    end else begin
      bat_partner = size;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_data.op == snp_pkg::OP_DIRECT) begin
              status    <= q_data.status;
              answer    <= q_data.answer;
              up_flag   <= 1'b0;
            end else begin
              op    <= q_data.op;
              rank  <= q_data.rank;
              lg    <= q_data.lg;
              size  <= q_data.size;
              rem   <= q_data.stage;
              level <= '0;
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (rem > snp_pkg::SIDX_W'(level)) begin
            rem   <= rem - snp_pkg::SIDX_W'(level) - snp_pkg::SIDX_W'(1);
            level <= level + snp_pkg::LVL_W'(1);
          end else begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          p_mask      <= p_next;
          gap         <= d_next;
          r_val       <= r_next;
          bit_partner <= {1'b0, rank ^ (snp_pkg::RANK_W'(1) << (level - rem_lo))};
          bit_up      <= rank_x[up_pos];
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            status    <= snp_pkg::ST_PARTNER;
            if (op == snp_pkg::OP_BITONIC) begin
              answer  <= bit_partner;
              up_flag <= bit_up;
            end else begin
              answer  <= bat_partner;
              up_flag <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/sorting_network_partner_unit.sv -----
// ----------------------------------------------------------------------------
// sorting_network_partner_unit
// Compare-exchange partner of a rank in a configurable sorting network.
// ----------------------------------------------------------------------------
// Usage:
//   Configure network_kind (byte address 0) and network_size (byte address 4)
//   over the APB-style port while the block is idle; pready is always high.
//   Queries enter through push/full as (rank, stage); each beat gives exactly
//   one result beat (status, answer, up_flag) on the empty/pop side, in order.
//   Hypercube, transposition, odd and even queries and count or finished answers
//   pass through the queue and then the result register before empty goes low.
//   Batcher and bitonic partners also pass the back sequencer, which walks one
//   level per cycle up to L, the level of the stage (0 .. 15), then picks and emits.
//   Direct kinds go at one beat per cycle while the receiver pops; the sequencer
//   takes no new beat before it emits a batcher or bitonic result; a two-entry
//   queue between classifier and sequencer lets push go on while a result waits.
//   When the receiver stalls the result holds on the ports, the sequencer
//   halts with its finished item and full rises once the queue fills.
//   Reset clears both registers to zero, empties the queue and the result.
// ----------------------------------------------------------------------------
module sorting_network_partner_unit (
  input  logic                                clk,
  input  logic                                rst,
  // query side
  input  logic                                push,
  output logic                                full,
  input  logic [snp_pkg::RANK_W-1:0]          rank,
  input  logic signed [snp_pkg::STAGE_W-1:0]  stage,
  // result side
  output logic                                empty,
  input  logic                                pop,
  output logic [snp_pkg::STATUS_W-1:0]        status,
  output logic [snp_pkg::ANS_W-1:0]           answer,
  output logic                                up_flag,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [snp_pkg::PADDR_W-1:0]         paddr,
  input  logic [snp_pkg::PDATA_W-1:0]         pwdata,
  output logic [snp_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  snp_pkg::cfg_t cfg;
  snp_pkg::cmd_t front_cmd;
  snp_pkg::cmd_t q_data;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          q_push;
  logic          cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind <= '0;
      cfg.size <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == snp_pkg::REG_KIND) cfg.kind <= pwdata[snp_pkg::KIND_W-1:0];
      else                               cfg.size <= pwdata[snp_pkg::SIZE_W-1:0];
    end
  end

  // register read back
  assign prdata = (paddr[2] == snp_pkg::REG_SIZE) ? snp_pkg::PDATA_W'(cfg.size)
                                                  : snp_pkg::PDATA_W'(cfg.kind);

  // front: classify the query
  snp_front u_front (
    .cfg   (cfg),
    .rank  (rank),
    .stage (stage),
    .cmd   (front_cmd)
  );

  assign full   = q_full;
  assign q_push = push && !q_full;

  // queue between front and back
  snp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (front_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // back: level walk and result register
  snp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .status  (status),
    .answer  (answer),
    .up_flag (up_flag)
  );

endmodule

// ----- rtl/core/snp_checker.sv -----
// ----------------------------------------------------------------------------
// snp_checker
// Port-level checks of the sorting network partner unit, bound to the top.
// ----------------------------------------------------------------------------
module snp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                empty,
  input logic                                pop,
  input logic [snp_pkg::STATUS_W-1:0]        status,
  input logic [snp_pkg::ANS_W-1:0]           answer,
  input logic                                up_flag
);

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // a finished result carries no answer and no flag
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == snp_pkg::ST_DONE) |-> (answer == '0 && !up_flag))
    else $error("finished result with nonzero payload");

  // only partner results carry the direction flag
  a_flag_partner: assert property (@(posedge clk) disable iff (rst)
    (!empty && up_flag) |-> (status == snp_pkg::ST_PARTNER))
    else $error("direction flag on a non-partner result");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(answer) && $stable(up_flag)))
    else $error("stalled result changed");

endmodule

bind sorting_network_partner_unit snp_checker u_snp_checker (.*);

// ----- sim/sorting_network_partner_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sorting_network_partner_unit_tb
// Self-checking bench for the sorting network partner unit: a built-in
// predictor works out the partner, stage count or finished answer of every
// query beat, and a checker compares each result beat in order. Directed
// corner cases come first, then random networks and queries with random
// stalls on both the query and the result side.
// ----------------------------------------------------------------------------
module sorting_network_partner_unit_tb;
  import snp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam logic [PADDR_W-1:0] ADDR_KIND = PADDR_W'({REG_KIND, 2'b00});
  localparam logic [PADDR_W-1:0] ADDR_SIZE = PADDR_W'({REG_SIZE, 2'b00});

  // one expected result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ANS_W-1:0]    answer;
    logic                up_flag;
  } partner_beat_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic [RANK_W-1:0]          rank = '0;
  logic signed [STAGE_W-1:0]  stage = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [STATUS_W-1:0]        status;
  logic [ANS_W-1:0]           answer;
  logic                       up_flag;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [PDATA_W-1:0]         pwdata = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;

  // mirror of the network registers
  logic [KIND_W-1:0] net_kind = KIND_HC_LH;
  logic [SIZE_W-1:0] net_size = '0;

  partner_beat_t expected_beats[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  bit            calm = 1'b0;

  sorting_network_partner_unit i_dut (.*);

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // random idle decision, switched off during calm stretches
  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 15);
  endfunction

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // floor log2 capped at the largest network level
  function automatic longint size_log2(input logic [SIZE_W-1:0] n);
    longint lg = 0;
    for (int b = 0; b < SIZE_W; b++) begin
      if (n[b]) lg = b;
    end
    if (lg > SIZE_LOG2_MAX) lg = SIZE_LOG2_MAX;
    return lg;
  endfunction

  function automatic longint count_stages(input logic [KIND_W-1:0] kind,
                                          input logic [SIZE_W-1:0] size);
    longint lg;
    longint n;
    lg = size_log2(size);
    n = size;
    case (kind)
      KIND_HC_LH, KIND_HC_HL: return lg;
      KIND_OET: return (n <= 2) ? n - 1 : n;
      KIND_ODD, KIND_EVEN: return 1;
      KIND_BATCHER, KIND_BITONIC: return lg * (lg + 1) / 2;
      default: return 0;
    endcase
  endfunction

  // neighbor kept inside the network, edge ranks may get themselves
  function automatic longint clamp_neighbor(input longint v, input longint n);
    if (v > n - 1) v = n - 1;
    if (v < 0) v = 0;
    return v;
  endfunction

  // merge-exchange partner; ranks left out of a stage get the network size
  function automatic longint merge_exchange_partner(input longint lg, input longint rank_v,
                                                    input longint stage_v, input longint n);
    longint unsigned top, p, q, r, d, rk;
    longint st;
    rk = rank_v;
    st = stage_v;
    top = 64'd1 << (lg - 1);
    for (p = top; p > 0; p >>= 1) begin
      q = top;
      r = 0;
      d = p;
      do begin
        if (st <= 0) begin
          if ((rk & p) == r) return longint'(rk + d);
          if (rk >= d && ((rk - d) & p) == r) return longint'(rk - d);
          return n;
        end
        st--;
        d = q - p;
        q >>= 1;
        r = p;
      end while (d != 0);
    end
    return -1;
  endfunction

  function automatic partner_beat_t predict_beat(input logic [KIND_W-1:0] kind,
                                                 input logic [SIZE_W-1:0] size,
                                                 input logic [RANK_W-1:0] rank_v,
                                                 input logic signed [STAGE_W-1:0] stage_v);
    partner_beat_t res;
    longint lg, stages, rk, st, n, partner, lvl;
    logic upf;
    rk = longint'(rank_v);
    st = longint'(stage_v);
    n = size;
    lg = size_log2(size);
    stages = count_stages(kind, size);
    res.status = ST_DONE;
    res.answer = '0;
    res.up_flag = 1'b0;
    upf = 1'b0;
    // no stages, rank outside, stage count, stage past the end
    if (stages <= 0 || rk >= n) return res;
    if (st < 0) begin
      res.status = ST_COUNT;
      res.answer = stages[ANS_W-1:0];
      return res;
    end
    if (st >= stages) return res;
    case (kind)
      KIND_HC_LH: partner = rk ^ (longint'(1) << st);
      KIND_HC_HL: partner = rk ^ (longint'(1) << (lg - 1 - st));
      KIND_OET: partner = clamp_neighbor(((st & 1) == (rk & 1)) ? rk + 1 : rk - 1, n);
      KIND_ODD: partner = clamp_neighbor(((rk & 1) == 0) ? rk + 1 : rk - 1, n);
      KIND_EVEN: partner = clamp_neighbor(((rk & 1) == 1) ? rk + 1 : rk - 1, n);
      KIND_BATCHER: partner = merge_exchange_partner(lg, rk, st, n);
      KIND_BITONIC: begin
        // walk the levels until the stage falls inside one
        lvl = 0;
        while (lvl < lg && st > lvl) begin
          lvl++;
          st -= lvl;
        end
        upf = ((rk >> (lvl + 1)) & 1) != 0;
        partner = rk ^ (longint'(1) << (lvl - st));
      end
      default: partner = -1;
    endcase
    if (partner < 0) return res;
    res.status = ST_PARTNER;
    res.answer = partner[ANS_W-1:0];
    res.up_flag = upf;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // result receiver with random stalls
  always @(negedge clk) begin
    pop <= !rst && !idle_roll();
  end

  task automatic report_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // compare each result beat with the oldest expected one
  always @(posedge clk) begin
    partner_beat_t exp_beat;
    if (!rst && pop && !empty) begin
      if (expected_beats.size() == 0) begin
        $display("%0t unexpected result beat: status %0d, answer %0d, up_flag %0d",
                 $time, status, answer, up_flag);
        error_count++;
      end else begin
        exp_beat = expected_beats.pop_front();
        report_field("status", 32'(exp_beat.status), 32'(status));
        report_field("answer", 32'(exp_beat.answer), 32'(answer));
        report_field("up_flag", 32'(exp_beat.up_flag), 32'(up_flag));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, expected_beats.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // query side and register access
  // ---------------------------------------------------------------------------

  task automatic send_query(input logic [RANK_W-1:0] r, input logic signed [STAGE_W-1:0] s);
    bit taken;
    taken = 1'b0;
    @(negedge clk);
    while (idle_roll()) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    rank <= r;
    stage <= s;
    while (!taken) begin
      @(posedge clk);
      if (!full) taken = 1'b1;
      else @(negedge clk);
    end
    expected_beats.push_back(predict_beat(net_kind, net_size, r, s));
  endtask

  // stop sending and wait until every expected result is in
  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_check(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] exp_v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== exp_v) begin
      $display("%0t mismatch on register read at %0d: expected %0d, actual %0d",
               $time, addr, exp_v, prdata);
      error_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write a register, then read it back
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_KIND) net_kind = value[KIND_W-1:0];
    else net_size = value[SIZE_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    read_check(addr, value);
  endtask

  task automatic set_network(input logic [KIND_W-1:0] kind, input logic [SIZE_W-1:0] size);
    drain_results();
    write_reg(ADDR_KIND, PDATA_W'(kind));
    write_reg(ADDR_SIZE, PDATA_W'(size));
  endtask

  // random network: small sizes, powers of two, random sizes up to 65536 and oversized ones
  task automatic pick_network();
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] size;
    int unsigned roll;
    kind = ($urandom_range(9) == 0) ? KIND_UNUSED : KIND_W'($urandom_range(6));
    roll = $urandom_range(99);
    if (roll < 40) size = SIZE_W'($urandom_range(20));
    else if (roll < 70) size = SIZE_W'(1) << $urandom_range(16);
    else if (roll < 95) size = SIZE_W'($urandom_range(65536));
    else size = SIZE_W'($urandom_range(131071, 65537));
    set_network(kind, size);
  endtask

  // mostly well-formed queries, the rest random noise
  task automatic random_query();
    longint stages, top_rank, past;
    int unsigned roll;
    logic [RANK_W-1:0] r;
    logic signed [STAGE_W-1:0] s;
    stages = count_stages(net_kind, net_size);
    roll = $urandom_range(99);
    if (roll < 85 && net_size != 0) begin
      top_rank = (net_size > 65536) ? 65535 : longint'(net_size) - 1;
      r = RANK_W'($urandom_range(32'(top_rank), 0));
      if (stages > 0 && roll < 75) begin
        s = STAGE_W'($urandom_range(32'(stages - 1), 0));
      end else if (roll < 80) begin
        s = '1;
      end else begin
        past = stages + $urandom_range(2);
        s = (past > 65535) ? 17'sd65535 : STAGE_W'(past);
      end
    end else begin
      r = RANK_W'($urandom);
      s = STAGE_W'($urandom);
    end
    send_query(r, s);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_register_reset();
    read_check(ADDR_KIND, '0);
    read_check(ADDR_SIZE, '0);
  endtask

  task automatic test_directed_cases();
    // no stages after reset
    send_query(16'd0, 17'sd0);
    // hypercube: count, partners, rank outside, stage past the end
    set_network(KIND_HC_LH, 17'd16);
    send_query(16'd0, '1);
    send_query(16'd5, 17'sd3);
    send_query(16'd15, 17'sd0);
    send_query(16'd16, 17'sd0);
    send_query(16'd3, 17'sd4);
    // oversized network, log2 capped
    set_network(KIND_HC_HL, 17'd131071);
    send_query(16'd65535, 17'sd0);
    send_query(16'd0, 17'sd15);
    send_query(16'd65535, 17'sh10000);
    // transposition with a single participant has no stages
    set_network(KIND_OET, 17'd1);
    send_query(16'd0, 17'sd0);
    set_network(KIND_OET, 17'd65536);
    send_query(16'd65535, 17'sd65535);
    send_query(16'd0, '1);
    // edge ranks clamp onto themselves
    set_network(KIND_OET, 17'd7);
    send_query(16'd6, 17'sd0);
    send_query(16'd0, 17'sd1);
    set_network(KIND_ODD, 17'd5);
    send_query(16'd4, 17'sd0);
    send_query(16'd0, 17'sd0);
    set_network(KIND_EVEN, 17'd5);
    send_query(16'd0, 17'sd0);
    send_query(16'd3, 17'sd0);
    // merge-exchange with a gap at the network size
    set_network(KIND_BATCHER, 17'd12);
    send_query(16'd7, 17'sd0);
    send_query(16'd8, 17'sd0);
    send_query(16'd9, 17'sd5);
    send_query(16'd11, '1);
    // bitonic, deepest stage and direction flag
    set_network(KIND_BITONIC, 17'd65536);
    send_query(16'd65535, 17'sd135);
    send_query(16'd1234, 17'sd40);
    send_query(16'd0, 17'sd0);
    // unused kind always finishes
    set_network(KIND_UNUSED, 17'd8);
    send_query(16'd1, 17'sd0);
  endtask

  task automatic test_random_queries();
    repeat (36) begin
      pick_network();
      repeat (30) random_query();
    end
  endtask

  // back-to-back beats with no idling on either side
  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (5) begin
      pick_network();
      repeat (30) random_query();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_register_reset();
    test_directed_cases();
    test_random_queries();
    test_back_to_back();
    drain_results();
    repeat (30) @(posedge clk);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
